FILE: hw/rtl/kmmrt_pkg.sv
// ----------------------------------------------------------------------------
// kmmrt_pkg
// Shared types and sizes for the keyed min/max range tracker.
// ----------------------------------------------------------------------------
package kmmrt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int SEEN_MAX    = 127;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_FINISH = 1'b1
    } t_req;

    typedef struct packed {
        logic               req_type;
        logic        [15:0] profile_id;
        logic        [15:0] bin_index;
        logic signed [31:0] angle_value;
    } t_item;

    typedef struct packed {
        logic        [15:0] key;
        logic        [15:0] low_bin;
        logic        [15:0] high_bin;
        logic signed [31:0] low_angle;
        logic signed [31:0] high_angle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage

FILE: hw/rtl/kmmrt_if.sv
// ----------------------------------------------------------------------------
// kmmrt request and result channels
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
interface kmmrt_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic        [15:0] profile_id;
    logic        [15:0] bin_index;
    logic signed [31:0] angle_value;

    modport source (output valid, req_type, profile_id, bin_index, angle_value,
                    input ready);
    modport sink   (input valid, req_type, profile_id, bin_index, angle_value,
                    output ready);
endinterface

interface kmmrt_res_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic        [15:0] win_profile;
    logic        [31:0] angle_span;
    logic signed [31:0] low_bin_angle;
    logic signed [31:0] high_bin_angle;
    logic        [15:0] low_bin;
    logic        [15:0] high_bin;
    logic               dropped_any;
    logic        [6:0]  profiles_seen;

    modport source (output valid, found, win_profile, angle_span, low_bin_angle,
                    high_bin_angle, low_bin, high_bin, dropped_any, profiles_seen,
                    input ready);
    modport sink   (input valid, found, win_profile, angle_span, low_bin_angle,
                    high_bin_angle, low_bin, high_bin, dropped_any, profiles_seen,
                    output ready);
endinterface

FILE: hw/rtl/kmmrt_ram.sv
// ----------------------------------------------------------------------------
// kmmrt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module kmmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/kmmrt_front.sv
// ----------------------------------------------------------------------------
// kmmrt_front
// Accepts requests into a two-entry queue ahead of the table engine.
// ----------------------------------------------------------------------------
module kmmrt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kmmrt_req_if.sink             i_req,
    output kmmrt_pkg::t_qhead     o_head,
    input  logic                  i_pop
);
    import kmmrt_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{i_req.req_type, i_req.profile_id, i_req.bin_index,
                           i_req.angle_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];
endmodule

FILE: hw/rtl/kmmrt_back.sv
// ----------------------------------------------------------------------------
// kmmrt_back
// Table engine: key search, min/max update, insert, finish scan and report.
// ----------------------------------------------------------------------------
module kmmrt_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kmmrt_pkg::t_qhead     i_head,
    output logic                  o_pop,
    kmmrt_res_if.source           o_res
);
    import kmmrt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CHK  = 5'b00100,
        S_SPAN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [ADDR_W-1:0]   r_idx;
    logic [FILL_W-1:0]   r_fill;
    logic                r_ovf;
    t_entry              r_entry;
    logic [31:0]         r_span;
    t_entry              r_best;
    logic [31:0]         r_best_span;
    logic                r_found;
    logic                r_out_valid;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    t_entry              ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd;
    t_entry              fresh, merged;
    logic                last, full;
    logic signed [32:0]  diff;
    logic [32:0]         mag;
    logic [31:0]         fill32;

    kmmrt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd    = t_entry'(ram_rdata);
    assign last  = (FILL_W'(r_idx) + FILL_W'(1)) == r_fill;
    assign full  = (r_fill == FILL_W'(TABLE_DEPTH));
    assign diff  = {rd.high_angle[31], rd.high_angle} - {rd.low_angle[31], rd.low_angle};
    assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign fill32 = 32'(r_fill);

    always_comb begin
        fresh = '{r_item.profile_id, r_item.bin_index, r_item.bin_index,
                  r_item.angle_value, r_item.angle_value};
        merged = rd;
        if (r_item.bin_index < rd.low_bin) begin
            merged.low_bin   = r_item.bin_index;
            merged.low_angle = r_item.angle_value;
        end
        if (r_item.bin_index > rd.high_bin) begin
            merged.high_bin   = r_item.bin_index;
            merged.high_angle = r_item.angle_value;
        end
    end

    // RAM port control and queue pop
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = merged;
        o_pop     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = i_head.valid;
                if (i_head.valid && i_head.item.req_type == REQ_SAMPLE
                    && r_fill == '0) begin
                    ram_we    = 1'b1;
                    ram_addr  = '0;
                    ram_wdata = '{i_head.item.profile_id, i_head.item.bin_index,
                                  i_head.item.bin_index, i_head.item.angle_value,
                                  i_head.item.angle_value};
                end
            end
            S_CHK: begin
                if (r_item.req_type == REQ_SAMPLE) begin
                    if (rd.key == r_item.profile_id) begin
                        ram_we = 1'b1;
                    end else if (last && !full) begin
                        ram_we    = 1'b1;
                        ram_addr  = r_fill[ADDR_W-1:0];
                        ram_wdata = fresh;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && r_state != S_EMIT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_item      <= i_head.item;
                        r_idx       <= '0;
                        r_found     <= 1'b0;
                        r_best_span <= '0;
                        if (r_fill == '0) begin
                            if (i_head.item.req_type == REQ_SAMPLE) begin
                                r_fill <= FILL_W'(1);
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_item.req_type == REQ_FINISH) begin
                        r_entry <= rd;
                        r_span  <= mag[31:0];
                        r_state <= S_SPAN;
                    end else if (rd.key == r_item.profile_id) begin
                        r_state <= S_IDLE;
                    end else if (last) begin
                        // new key: insert, or drop when the table is full
                        if (full) r_ovf  <= 1'b1;
                        else      r_fill <= r_fill + FILL_W'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + ADDR_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_SPAN: begin
                    if (r_span > r_best_span) begin
                        r_best      <= r_entry;
                        r_best_span <= r_span;
                        r_found     <= 1'b1;
                    end
                    if (last) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + ADDR_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    // hold until the result register is free
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid          <= 1'b1;
                        o_res.found          <= r_found;
                        o_res.win_profile    <= r_found ? r_best.key : '0;
                        o_res.angle_span     <= r_found ? r_best_span : '0;
                        o_res.low_bin_angle  <= r_found ? r_best.low_angle : '0;
                        o_res.high_bin_angle <= r_found ? r_best.high_angle : '0;
                        o_res.low_bin        <= r_found ? r_best.low_bin : '0;
                        o_res.high_bin       <= r_found ? r_best.high_bin : '0;
                        o_res.dropped_any    <= r_ovf;
                        o_res.profiles_seen  <= (fill32 > 32'(SEEN_MAX)) ?
                                                7'(SEEN_MAX) : fill32[6:0];
                        r_fill  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (o_res.valid && o_res.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid = r_out_valid;
endmodule

FILE: hw/rtl/keyed_min_max_range_tracker.sv
// ----------------------------------------------------------------------------
// keyed_min_max_range_tracker
// Per-profile min/max bin tracking with a finish scan for the widest span.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  i_req    in   valid/ready  req_type, profile_id, bin_index, angle_value
//  o_res    out  valid/ready  found .. profiles_seen (one per finish request)
//
// A sample searches the held table entries in turn (RAM read then compare)
// until its key matches or none is left; the single-port table RAM sets this.
// A finish reads, compares and spans every held entry, then reports and clears.
// Reset is synchronous, active low; the table needs no clearing pass.
// A two-entry request queue keeps accepting, until it is full, while the
// engine works or the result register waits on o_res.ready.
// ----------------------------------------------------------------------------
module keyed_min_max_range_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmmrt_req_if.sink   i_req,
    kmmrt_res_if.source o_res
);
    import kmmrt_pkg::*;

    t_qhead head;
    logic   pop;

    kmmrt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    kmmrt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule

FILE: hw/rtl/kmmrt_chk.sv
// ----------------------------------------------------------------------------
// kmmrt_chk
// Port-level checks on the result channel of the range tracker.
// ----------------------------------------------------------------------------
module kmmrt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_found,
    input logic [15:0] i_win_profile,
    input logic [31:0] i_angle_span,
    input logic [15:0] i_low_bin,
    input logic [15:0] i_high_bin,
    input logic [6:0]  i_profiles_seen
);
    import kmmrt_pkg::*;

    // stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_found |-> i_win_profile == 16'd0 && i_angle_span == 32'd0)
        else $error("empty result carries data");

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_found |-> i_angle_span != 32'd0 && i_low_bin <= i_high_bin
                                   && i_profiles_seen != 7'd0)
        else $error("found result inconsistent");

    a_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> 32'(i_profiles_seen) <= TABLE_DEPTH)
        else $error("profile count exceeds table");
endmodule

bind keyed_min_max_range_tracker kmmrt_chk u_kmmrt_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_found         (o_res.found),
    .i_win_profile   (o_res.win_profile),
    .i_angle_span    (o_res.angle_span),
    .i_low_bin       (o_res.low_bin),
    .i_high_bin      (o_res.high_bin),
    .i_profiles_seen (o_res.profiles_seen)
);

FILE: tb/kmmrt_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmmrt testbench channel helpers
// Idle-pattern helper shared by the request driver and the result sink.
// ----------------------------------------------------------------------------
package kmmrt_tb_pkg;

    // idle on about 16 of every 100 calls unless quiet
    function automatic bit want_idle(bit quiet);
        return !quiet && ($urandom_range(99, 0) < 16);
    endfunction

endpackage

FILE: tb/keyed_min_max_range_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_min_max_range_tracker_tb
// Drives samples and finish requests, predicts each finish report from a
// behavioral copy of the profile table and compares every result field.
// ----------------------------------------------------------------------------
module keyed_min_max_range_tracker_tb;
    import kmmrt_pkg::*;
    import kmmrt_tb_pkg::*;

    typedef struct {
        logic        found;
        logic [15:0] win_profile;
        logic [31:0] angle_span;
        logic [31:0] low_bin_angle;
        logic [31:0] high_bin_angle;
        logic [15:0] low_bin;
        logic [15:0] high_bin;
        logic        dropped_any;
        logic [6:0]  profiles_seen;
    } t_report;

    class span_scoreboard;
        t_entry      tbl[TABLE_DEPTH];
        int          fill;
        bit          overflow;
        t_report     pending[$];
        int          errors;

        function void note_request(t_req kind, logic [15:0] key, logic [15:0] bin,
                                   logic signed [31:0] ang);
            t_report r;
            longint  best_span;
            longint  d;
            int      best;
            if (kind == REQ_SAMPLE) begin
                for (int i = 0; i < fill; i++) begin
                    if (tbl[i].key == key) begin
                        if (bin < tbl[i].low_bin) begin
                            tbl[i].low_bin   = bin;
                            tbl[i].low_angle = ang;
                        end
                        if (bin > tbl[i].high_bin) begin
                            tbl[i].high_bin   = bin;
                            tbl[i].high_angle = ang;
                        end
                        return;
                    end
                end
                if (fill < TABLE_DEPTH) begin
                    tbl[fill] = '{key, bin, bin, ang, ang};
                    fill++;
                end else begin
                    overflow = 1;
                end
                return;
            end
            best_span = 0;
            best = -1;
            for (int i = 0; i < fill; i++) begin
                d = longint'(tbl[i].high_angle) - longint'(tbl[i].low_angle);
                if (d < 0) d = -d;
                if (d > best_span) begin
                    best_span = d;
                    best = i;
                end
            end
            r = '{default: '0};
            if (best >= 0) begin
                r.found          = 1;
                r.win_profile    = tbl[best].key;
                r.angle_span     = best_span[31:0];
                r.low_bin_angle  = tbl[best].low_angle;
                r.high_bin_angle = tbl[best].high_angle;
                r.low_bin        = tbl[best].low_bin;
                r.high_bin       = tbl[best].high_bin;
            end
            r.dropped_any   = overflow;
            r.profiles_seen = (fill > SEEN_MAX) ? 7'(SEEN_MAX) : 7'(fill);
            pending.push_back(r);
            fill = 0;
            overflow = 0;
        endfunction

        function void check_report(t_report got);
            t_report w;
            if (pending.size() == 0) begin
                $error("unexpected result, found=%0d", got.found);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.found !== w.found) begin
                $error("found exp %0h got %0h", w.found, got.found); errors++;
            end
            if (got.win_profile !== w.win_profile) begin
                $error("win_profile exp %0h got %0h", w.win_profile, got.win_profile);
                errors++;
            end
            if (got.angle_span !== w.angle_span) begin
                $error("angle_span exp %0h got %0h", w.angle_span, got.angle_span);
                errors++;
            end
            if (got.low_bin_angle !== w.low_bin_angle) begin
                $error("low_bin_angle exp %0h got %0h", w.low_bin_angle, got.low_bin_angle);
                errors++;
            end
            if (got.high_bin_angle !== w.high_bin_angle) begin
                $error("high_bin_angle exp %0h got %0h", w.high_bin_angle,
                       got.high_bin_angle);
                errors++;
            end
            if (got.low_bin !== w.low_bin) begin
                $error("low_bin exp %0h got %0h", w.low_bin, got.low_bin); errors++;
            end
            if (got.high_bin !== w.high_bin) begin
                $error("high_bin exp %0h got %0h", w.high_bin, got.high_bin); errors++;
            end
            if (got.dropped_any !== w.dropped_any) begin
                $error("dropped_any exp %0h got %0h", w.dropped_any, got.dropped_any);
                errors++;
            end
            if (got.profiles_seen !== w.profiles_seen) begin
                $error("profiles_seen exp %0d got %0d", w.profiles_seen, got.profiles_seen);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    kmmrt_req_if req_ch();
    kmmrt_res_if res_ch();

    keyed_min_max_range_tracker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    span_scoreboard sb;
    bit  send_quiet;
    bit  recv_quiet;
    bit  hold_results;
    logic [15:0] key_pool[8];

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    initial begin
        #4_000_000;
        $display("keyed_min_max_range_tracker_tb: errors");
        $finish;
    end

    // drive one request; valid held until accepted at a rising edge
    task automatic send_request(t_req kind, logic [15:0] key, logic [15:0] bin,
                                logic signed [31:0] ang);
        while (want_idle(send_quiet)) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.profile_id  <= key;
        req_ch.bin_index   <= bin;
        req_ch.angle_value <= ang;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(kind, key, bin, ang);
        @(negedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] key, logic [15:0] bin, logic signed [31:0] ang);
        send_request(REQ_SAMPLE, key, bin, ang);
    endtask

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(5, 0))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            default: return $signed($urandom);
        endcase
    endfunction

    // result sink
    initial begin
        t_report got;
        int      hold;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_results) begin
                res_ch.ready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(negedge i_clk);
                hold_results = 0;
            end
            res_ch.ready <= !want_idle(recv_quiet);
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                got.found          = res_ch.found;
                got.win_profile    = res_ch.win_profile;
                got.angle_span     = res_ch.angle_span;
                got.low_bin_angle  = res_ch.low_bin_angle;
                got.high_bin_angle = res_ch.high_bin_angle;
                got.low_bin        = res_ch.low_bin;
                got.high_bin       = res_ch.high_bin;
                got.dropped_any    = res_ch.dropped_any;
                got.profiles_seen  = res_ch.profiles_seen;
                sb.check_report(got);
            end
            @(negedge i_clk);
        end
    end

    initial begin
        int n_items;
        int grp;
        int wait_cycles;
        sb = new();
        send_quiet = 0;
        recv_quiet = 0;
        hold_results = 0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_SAMPLE;
        req_ch.profile_id = '0;
        req_ch.bin_index = '0;
        req_ch.angle_value = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty finish, extremes, ties, equal-bin no-replace
        send_request(REQ_FINISH, 16'hffff, 16'hffff, 32'sh7fff_ffff);
        send_sample(16'h0000, 16'h0000, 32'sh8000_0000);
        send_sample(16'h0000, 16'hffff, 32'sh7fff_ffff);
        send_sample(16'h0000, 16'hffff, 32'sh0);
        send_sample(16'h0000, 16'h0000, 32'sh0);
        send_sample(16'hffff, 16'h1000, 32'sh0001_0000);
        send_request(REQ_FINISH, 16'h0, 16'h0, 32'sh0);
        send_sample(16'h0005, 16'h0010, 32'sh0000_0100);
        send_sample(16'h0005, 16'h0020, 32'sh0000_0000);
        send_sample(16'h0006, 16'h0020, 32'sh0000_0100);
        send_sample(16'h0006, 16'h0010, 32'sh0000_0000);
        send_sample(16'h0007, 16'h0030, 32'sh1234_5678);
        send_request(REQ_FINISH, 16'h0, 16'h0, 32'sh0);
        // fill past the table to hit the drop path
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
            send_sample(16'(16'h0100 + i), 16'($urandom), rand_angle());
        send_sample(16'h0100, 16'($urandom), rand_angle());
        send_request(REQ_FINISH, 16'h0, 16'h0, 32'sh0);

        // random: groups of samples over a small key pool, then a finish
        n_items = 0;
        grp = 0;
        while (n_items < 860) begin
            foreach (key_pool[k]) key_pool[k] = 16'($urandom);
            send_quiet = (grp % 10) == 3;
            recv_quiet = send_quiet;
            if (grp == 5) hold_results = 1;
            repeat ($urandom_range(12, 0)) begin
                if ($urandom_range(9, 0) == 0)
                    send_sample(16'($urandom), 16'($urandom), rand_angle());
                else
                    send_sample(key_pool[$urandom_range(7, 0)],
                                $urandom_range(1, 0) ? 16'($urandom)
                                                     : 16'($urandom_range(15, 0)),
                                rand_angle());
                n_items++;
            end
            send_request(REQ_FINISH, 16'($urandom), 16'($urandom), $signed($urandom));
            n_items++;
            grp++;
        end
        req_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (400) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("keyed_min_max_range_tracker_tb: clean");
        else
            $display("keyed_min_max_range_tracker_tb: errors");
        $finish;
    end
endmodule
